@@ hdl/arpr_pkg.sv @@
`timescale 1ns / 1ps

package arpr_pkg;

    // input beat
    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] hop_ip;
        logic [15:0] datagram_handle;
        logic [47:0] frame_dst_mac;
        logic [15:0] frame_ethertype;
        logic        payload_ok;
        logic [15:0] arp_opcode;
        logic [31:0] arp_sender_ip;
        logic [47:0] arp_sender_mac;
        logic [31:0] arp_target_ip;
        logic [15:0] elapsed_ms;
    } arpr_in_t;

    // result beat
    typedef struct packed {
        logic [1:0]  out_kind;
        logic [47:0] out_dst_mac;
        logic [31:0] out_target_ip;
        logic [47:0] out_target_mac;
        logic [15:0] out_handle;
        logic        out_last;
    } arpr_out_t;

    // sequencer to output stage
    typedef struct packed {
        logic push;
        logic flush;
    } arpr_emit_ctl_t;

    // output stage to sequencer
    typedef struct packed {
        logic can_emit;
        logic hold_valid;
    } arpr_emit_sts_t;

    localparam logic [1:0] REQ_SEND  = 2'd0;
    localparam logic [1:0] REQ_FRAME = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [1:0] KIND_IPV4      = 2'd0;
    localparam logic [1:0] KIND_ARP_REQ   = 2'd1;
    localparam logic [1:0] KIND_ARP_REPLY = 2'd2;
    localparam logic [1:0] KIND_DELIVER   = 2'd3;

    localparam logic [15:0] ETH_IPV4       = 16'h0800;
    localparam logic [15:0] ETH_ARP        = 16'h0806;
    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY   = 16'd2;
    localparam logic [47:0] BCAST_MAC      = 48'hFFFF_FFFF_FFFF;

    localparam int MAX_RESULTS  = 16;
    localparam int RESULT_CNT_W = 5;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam logic [2:0] CFG_LOCAL_MAC   = 3'd0;
    localparam logic [2:0] CFG_LOCAL_IP    = 3'd1;
    localparam logic [2:0] CFG_CACHE_TTL   = 3'd2;
    localparam logic [2:0] CFG_REQ_TIMEOUT = 3'd3;
    localparam logic [2:0] CFG_MAX_RETRIES = 3'd4;

    localparam logic [31:0] TTL_RESET     = 32'd30000;
    localparam logic [31:0] TIMEOUT_RESET = 32'd5000;
    localparam logic [7:0]  RETRIES_RESET = 8'd3;

endpackage

@@ hdl/arpr_out_stage.sv @@
`timescale 1ns / 1ps

module arpr_out_stage import arpr_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  arpr_emit_ctl_t ctl,
    input  arpr_out_t      emit_data,
    output arpr_emit_sts_t sts,
    output logic           m_valid,
    input  logic           m_ready,
    output arpr_out_t      m_data
);

    logic      hold_vld_reg;
    arpr_out_t hold_data_reg;
    logic      m_valid_reg;
    arpr_out_t m_data_reg;
    arpr_out_t hold_final;
    logic      can_emit;
    logic      can_flush;
    logic      push_fire;
    logic      flush_fire;

    // one result is held back until we know whether it is the last one
    always_comb begin
        hold_final          = hold_data_reg;
        hold_final.out_last = 1'b1;
    end

    assign can_emit   = !hold_vld_reg || !m_valid_reg || m_ready;
    assign can_flush  = !m_valid_reg || m_ready;
    assign push_fire  = ctl.push && can_emit;
    assign flush_fire = ctl.flush && hold_vld_reg && can_flush;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (push_fire) begin
            hold_vld_reg <= 1'b1;
            if (hold_vld_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end else if (flush_fire) begin
            hold_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (push_fire) begin
            hold_data_reg <= emit_data;
            if (hold_vld_reg) begin
                m_data_reg <= hold_data_reg;
            end
        end else if (flush_fire) begin
            m_data_reg <= hold_final;
        end
    end

    assign sts.can_emit   = can_emit;
    assign sts.hold_valid = hold_vld_reg;
    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;

endmodule

@@ hdl/arp_resolver_with_retry_core.sv @@
`timescale 1ns / 1ps
// ARP resolver with retry: IP-to-MAC cache, outstanding request table and
// pending datagram pool, each in a synchronous simple dual-port memory.
// Channels: s_* takes one item per beat (send, received frame or tick),
// m_* gives result beats, out_last marks the last beat of an item, and
// cfg_* writes the five configuration registers (index 0..4); the user must
// write them only while idle, the block itself does not enforce it.
// One item is worked at a time. Each table scan reads an entry from memory,
// then checks it and writes back; a tick that abandons a request adds a
// compaction pass over the pending pool, and a send ends its cache scan
// at the first hit. Each result waits in a hold register until the next
// one is found or the scan ends, so the first beat leaves only then; the
// last one moves to the output register, marked last, after its scan
// ends. Results pass through the hold register and an output register, so
// the scan runs on while one beat waits; when the receiver stalls with both
// full, the scan pauses at its next result.
// Reset clears all valid bits, the pending count and time and resets the
// registers; no clearing pass is needed, s_ready rises once reset is released.

module arp_resolver_with_retry_core import arpr_pkg::*; #(
    parameter int CACHE_ENTRIES   = 8,
    parameter int REQUEST_ENTRIES = 8,
    parameter int PENDING_ENTRIES = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  arpr_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output arpr_out_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CAW   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int RAW   = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
    localparam int PAW   = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int MAXN0 = (CACHE_ENTRIES > REQUEST_ENTRIES) ? CACHE_ENTRIES
                                                             : REQUEST_ENTRIES;
    localparam int MAXN  = (MAXN0 > PENDING_ENTRIES) ? MAXN0 : PENDING_ENTRIES;
    localparam int IDX_W = $clog2(MAXN + 1);
    localparam int PCW   = $clog2(PENDING_ENTRIES + 1);

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] stamp;
    } cache_ent_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [31:0] stamp;
        logic [7:0]  retries;
    } req_ent_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] handle;
    } pend_ent_t;

    typedef enum logic [12:0] {
        S_IDLE       = 13'h0001,
        S_SND_CACHE  = 13'h0002,
        S_SND_REQ    = 13'h0004,
        S_SND_ASK    = 13'h0008,
        S_DELIVER    = 13'h0010,
        S_REPLY      = 13'h0020,
        S_TAKE       = 13'h0040,
        S_LEARN      = 13'h0080,
        S_LEARN_WR   = 13'h0100,
        S_DROP       = 13'h0200,
        S_TICK_CACHE = 13'h0400,
        S_TICK_REQ   = 13'h0800,
        S_FIN        = 13'h1000
    } state_t;

    // configuration
    logic [47:0] local_mac_reg;
    logic [31:0] local_ip_reg;
    logic [31:0] ttl_reg;
    logic [31:0] timeout_reg;
    logic [7:0]  max_retries_reg;

    // control
    state_t                  state_reg;
    logic                    phase_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        r_reg;
    logic [IDX_W-1:0]        w_reg;
    logic [PCW-1:0]          pcnt_reg;
    logic [31:0]             now_reg;
    logic [CACHE_ENTRIES-1:0]   cache_vld_reg;
    logic [REQUEST_ENTRIES-1:0] req_vld_reg;
    logic                    asked_reg;
    logic                    hit_reg;
    logic [CAW-1:0]          hit_idx_reg;
    logic [CAW-1:0]          oldest_idx_reg;
    logic [31:0]             best_age_reg;
    logic                    take_emit_reg;
    logic [31:0]             take_ip_reg;
    logic [RESULT_CNT_W-1:0] n_reg;
    arpr_in_t                item_reg;

    // memories
    cache_ent_t cache_mem [CACHE_ENTRIES];
    req_ent_t   req_mem   [REQUEST_ENTRIES];
    pend_ent_t  pend_mem  [PENDING_ENTRIES];
    cache_ent_t crd_reg;
    req_ent_t   rrd_reg;
    pend_ent_t  prd_reg;

    logic       cache_we;
    logic [CAW-1:0] cache_waddr;
    cache_ent_t cache_wdata;
    logic       req_we;
    logic [RAW-1:0] req_waddr;
    req_ent_t   req_wdata;
    logic       pend_we;
    logic [PAW-1:0] pend_waddr;
    pend_ent_t  pend_wdata;

    logic [CAW-1:0] ci;
    logic [RAW-1:0] ri;
    logic [PAW-1:0] pi;
    logic [31:0]    c_age;
    logic [31:0]    r_age;
    logic           c_free_found;
    logic [CAW-1:0] c_free_idx;
    logic           r_free_found;
    logic [RAW-1:0] r_free_idx;
    logic [CAW-1:0] learn_slot;
    logic           room;
    logic           pend_room;
    logic           frame_for_us;
    logic           r_expired;
    logic           stall;
    logic           s_fire;

    arpr_emit_ctl_t emit_ctl;
    arpr_emit_sts_t emit_sts;
    arpr_out_t      emit_data;

    assign ci        = idx_reg[CAW-1:0];
    assign ri        = idx_reg[RAW-1:0];
    assign pi        = r_reg[PAW-1:0];
    assign c_age     = now_reg - crd_reg.stamp;
    assign r_age     = now_reg - rrd_reg.stamp;
    assign room      = n_reg < RESULT_CNT_W'(MAX_RESULTS);
    assign pend_room = pcnt_reg < PCW'(PENDING_ENTRIES);
    assign r_expired = req_vld_reg[ri] && (r_age >= timeout_reg);
    assign s_ready   = aresetn && (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = aresetn;
    assign frame_for_us = ((s_data.frame_dst_mac == local_mac_reg) ||
                           (s_data.frame_dst_mac == BCAST_MAC)) && s_data.payload_ok;

    // first free cache and request slots
    always_comb begin
        c_free_found = 1'b0;
        c_free_idx   = '0;
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (!c_free_found && !cache_vld_reg[i]) begin
                c_free_found = 1'b1;
                c_free_idx   = CAW'(i);
            end
        end
    end

    always_comb begin
        r_free_found = 1'b0;
        r_free_idx   = '0;
        for (int i = 0; i < REQUEST_ENTRIES; i++) begin
            if (!r_free_found && !req_vld_reg[i]) begin
                r_free_found = 1'b1;
                r_free_idx   = RAW'(i);
            end
        end
    end

    // learn target: existing mapping, then a free slot, then the oldest
    always_comb begin
        if (hit_reg) begin
            learn_slot = hit_idx_reg;
        end else if (c_free_found) begin
            learn_slot = c_free_idx;
        end else begin
            learn_slot = oldest_idx_reg;
        end
    end

    // result generation
    always_comb begin
        emit_ctl.push  = 1'b0;
        emit_ctl.flush = (state_reg == S_FIN);
        emit_data      = '0;
        unique case (state_reg)
            S_SND_CACHE: begin
                if (phase_reg && cache_vld_reg[ci] &&
                    crd_reg.ip == item_reg.hop_ip) begin
                    emit_ctl.push         = room;
                    emit_data.out_kind    = KIND_IPV4;
                    emit_data.out_dst_mac = crd_reg.mac;
                    emit_data.out_handle  = item_reg.datagram_handle;
                end
            end
            S_SND_ASK: begin
                emit_ctl.push           = !asked_reg && room;
                emit_data.out_kind      = KIND_ARP_REQ;
                emit_data.out_dst_mac   = BCAST_MAC;
                emit_data.out_target_ip = item_reg.hop_ip;
            end
            S_DELIVER: begin
                emit_ctl.push        = room;
                emit_data.out_kind   = KIND_DELIVER;
                emit_data.out_handle = item_reg.datagram_handle;
            end
            S_REPLY: begin
                emit_ctl.push            = room;
                emit_data.out_kind       = KIND_ARP_REPLY;
                emit_data.out_dst_mac    = item_reg.arp_sender_mac;
                emit_data.out_target_ip  = item_reg.arp_sender_ip;
                emit_data.out_target_mac = item_reg.arp_sender_mac;
            end
            S_TAKE: begin
                if (phase_reg && prd_reg.ip == take_ip_reg && take_emit_reg) begin
                    emit_ctl.push         = room;
                    emit_data.out_kind    = KIND_IPV4;
                    emit_data.out_dst_mac = item_reg.arp_sender_mac;
                    emit_data.out_handle  = prd_reg.handle;
                end
            end
            S_TICK_REQ: begin
                if (phase_reg && r_expired && rrd_reg.retries < max_retries_reg) begin
                    emit_ctl.push           = room;
                    emit_data.out_kind      = KIND_ARP_REQ;
                    emit_data.out_dst_mac   = BCAST_MAC;
                    emit_data.out_target_ip = rrd_reg.ip;
                end
            end
            default: begin
            end
        endcase
    end

    assign stall = emit_ctl.push && !emit_sts.can_emit;

    // memory write requests
    always_comb begin
        cache_we    = (state_reg == S_LEARN_WR);
        cache_waddr = learn_slot;
        cache_wdata = '{ip: item_reg.arp_sender_ip, mac: item_reg.arp_sender_mac,
                        stamp: now_reg};
        req_we      = 1'b0;
        req_waddr   = r_free_idx;
        req_wdata   = '{ip: item_reg.hop_ip, stamp: now_reg, retries: 8'd0};
        pend_we     = 1'b0;
        pend_waddr  = pcnt_reg[PAW-1:0];
        pend_wdata  = '{ip: item_reg.hop_ip, handle: item_reg.datagram_handle};
        if (state_reg == S_SND_ASK && !stall) begin
            req_we  = !asked_reg && r_free_found;
            pend_we = pend_room;
        end
        if (state_reg == S_TICK_REQ && phase_reg && r_expired &&
            rrd_reg.retries < max_retries_reg && !stall) begin
            req_we    = 1'b1;
            req_waddr = ri;
            req_wdata = '{ip: rrd_reg.ip, stamp: now_reg, retries: rrd_reg.retries + 8'd1};
        end
        if (state_reg == S_TAKE && phase_reg && prd_reg.ip != take_ip_reg) begin
            pend_we    = 1'b1;
            pend_waddr = w_reg[PAW-1:0];
            pend_wdata = prd_reg;
        end
    end

    // table memories, registered read
    always_ff @(posedge aclk) begin
        if (cache_we) begin
            cache_mem[cache_waddr] <= cache_wdata;
        end
        crd_reg <= cache_mem[ci];
    end

    always_ff @(posedge aclk) begin
        if (req_we) begin
            req_mem[req_waddr] <= req_wdata;
        end
        rrd_reg <= req_mem[ri];
    end

    always_ff @(posedge aclk) begin
        if (pend_we) begin
            pend_mem[pend_waddr] <= pend_wdata;
        end
        prd_reg <= pend_mem[pi];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_mac_reg   <= '0;
            local_ip_reg    <= '0;
            ttl_reg         <= TTL_RESET;
            timeout_reg     <= TIMEOUT_RESET;
            max_retries_reg <= RETRIES_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LOCAL_MAC:   local_mac_reg   <= cfg_data;
                CFG_LOCAL_IP:    local_ip_reg    <= cfg_data[31:0];
                CFG_CACHE_TTL:   ttl_reg         <= cfg_data[31:0];
                CFG_REQ_TIMEOUT: timeout_reg     <= cfg_data[31:0];
                CFG_MAX_RETRIES: max_retries_reg <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // item payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_data;
        end
    end

    // result counter per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= '0;
        end else if (s_fire) begin
            n_reg <= '0;
        end else if (emit_ctl.push && emit_sts.can_emit) begin
            n_reg <= n_reg + RESULT_CNT_W'(1);
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_reg      <= 1'b0;
            idx_reg        <= '0;
            r_reg          <= '0;
            w_reg          <= '0;
            pcnt_reg       <= '0;
            now_reg        <= '0;
            cache_vld_reg  <= '0;
            req_vld_reg    <= '0;
            asked_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            oldest_idx_reg <= '0;
            best_age_reg   <= '0;
            take_emit_reg  <= 1'b0;
            take_ip_reg    <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        idx_reg   <= '0;
                        phase_reg <= 1'b0;
                        asked_reg <= 1'b0;
                        hit_reg   <= 1'b0;
                        case (s_data.req_type)
                            REQ_SEND: state_reg <= S_SND_CACHE;
                            REQ_FRAME: begin
                                if (!frame_for_us) begin
                                    state_reg <= S_FIN;
                                end else if (s_data.frame_ethertype == ETH_IPV4) begin
                                    state_reg <= S_DELIVER;
                                end else if (s_data.frame_ethertype == ETH_ARP &&
                                             s_data.arp_target_ip == local_ip_reg &&
                                             s_data.arp_opcode == ARP_OP_REQUEST) begin
                                    state_reg <= S_REPLY;
                                end else if (s_data.frame_ethertype == ETH_ARP &&
                                             s_data.arp_target_ip == local_ip_reg &&
                                             s_data.arp_opcode == ARP_OP_REPLY) begin
                                    take_ip_reg   <= s_data.arp_sender_ip;
                                    take_emit_reg <= 1'b1;
                                    r_reg         <= '0;
                                    w_reg         <= '0;
                                    state_reg     <= S_TAKE;
                                end else begin
                                    state_reg <= S_FIN;
                                end
                            end
                            REQ_TICK: begin
                                now_reg   <= now_reg + 32'(s_data.elapsed_ms);
                                state_reg <= S_TICK_CACHE;
                            end
                            default: state_reg <= S_FIN;
                        endcase
                    end
                end
                S_SND_CACHE: begin
                    if (!phase_reg) begin
                        if (idx_reg == IDX_W'(CACHE_ENTRIES)) begin
                            idx_reg   <= '0;
                            state_reg <= S_SND_REQ;
                        end else begin
                            phase_reg <= 1'b1;
                        end
                    end else if (cache_vld_reg[ci] && crd_reg.ip == item_reg.hop_ip) begin
                        if (!stall) begin
                            state_reg <= S_FIN;
                        end
                    end else begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        phase_reg <= 1'b0;
                    end
                end
                S_SND_REQ: begin
                    if (!phase_reg) begin
                        if (idx_reg == IDX_W'(REQUEST_ENTRIES)) begin
                            state_reg <= S_SND_ASK;
                        end else begin
                            phase_reg <= 1'b1;
                        end
                    end else begin
                        if (req_vld_reg[ri] && rrd_reg.ip == item_reg.hop_ip) begin
                            asked_reg <= 1'b1;
                        end
                        idx_reg   <= idx_reg + IDX_W'(1);
                        phase_reg <= 1'b0;
                    end
                end
                S_SND_ASK: begin
                    if (!stall) begin
                        if (!asked_reg && r_free_found) begin
                            req_vld_reg[r_free_idx] <= 1'b1;
                        end
                        if (pend_room) begin
                            pcnt_reg <= pcnt_reg + PCW'(1);
                        end
                        state_reg <= S_FIN;
                    end
                end
                S_DELIVER: begin
                    if (!stall) begin
                        state_reg <= S_FIN;
                    end
                end
                S_REPLY: begin
                    if (!stall) begin
                        idx_reg   <= '0;
                        phase_reg <= 1'b0;
                        state_reg <= S_LEARN;
                    end
                end
                // pull every entry for take_ip out, compacting the rest in order
                S_TAKE: begin
                    if (!phase_reg) begin
                        if (r_reg == IDX_W'(pcnt_reg)) begin
                            pcnt_reg <= w_reg[PCW-1:0];
                            if (take_emit_reg) begin
                                idx_reg   <= '0;
                                state_reg <= S_LEARN;
                            end else begin
                                state_reg <= S_TICK_REQ;
                            end
                        end else begin
                            phase_reg <= 1'b1;
                        end
                    end else if (prd_reg.ip == take_ip_reg) begin
                        if (!stall) begin
                            r_reg     <= r_reg + IDX_W'(1);
                            phase_reg <= 1'b0;
                        end
                    end else begin
                        w_reg     <= w_reg + IDX_W'(1);
                        r_reg     <= r_reg + IDX_W'(1);
                        phase_reg <= 1'b0;
                    end
                end
                S_LEARN: begin
                    if (!phase_reg) begin
                        if (idx_reg == IDX_W'(CACHE_ENTRIES)) begin
                            state_reg <= S_LEARN_WR;
                        end else begin
                            phase_reg <= 1'b1;
                        end
                    end else begin
                        if (!hit_reg && cache_vld_reg[ci] &&
                            crd_reg.ip == item_reg.arp_sender_ip) begin
                            hit_reg     <= 1'b1;
                            hit_idx_reg <= ci;
                        end
                        if (idx_reg == '0 || c_age > best_age_reg) begin
                            best_age_reg   <= c_age;
                            oldest_idx_reg <= ci;
                        end
                        idx_reg   <= idx_reg + IDX_W'(1);
                        phase_reg <= 1'b0;
                    end
                end
                S_LEARN_WR: begin
                    cache_vld_reg[learn_slot] <= 1'b1;
                    idx_reg   <= '0;
                    phase_reg <= 1'b0;
                    state_reg <= S_DROP;
                end
                S_DROP: begin
                    if (!phase_reg) begin
                        if (idx_reg == IDX_W'(REQUEST_ENTRIES)) begin
                            state_reg <= S_FIN;
                        end else begin
                            phase_reg <= 1'b1;
                        end
                    end else begin
                        if (req_vld_reg[ri] && rrd_reg.ip == item_reg.arp_sender_ip) begin
                            req_vld_reg[ri] <= 1'b0;
                        end
                        idx_reg   <= idx_reg + IDX_W'(1);
                        phase_reg <= 1'b0;
                    end
                end
                // age out stale mappings
                S_TICK_CACHE: begin
                    if (!phase_reg) begin
                        if (idx_reg == IDX_W'(CACHE_ENTRIES)) begin
                            idx_reg   <= '0;
                            state_reg <= S_TICK_REQ;
                        end else begin
                            phase_reg <= 1'b1;
                        end
                    end else begin
                        if (cache_vld_reg[ci] && c_age > ttl_reg) begin
                            cache_vld_reg[ci] <= 1'b0;
                        end
                        idx_reg   <= idx_reg + IDX_W'(1);
                        phase_reg <= 1'b0;
                    end
                end
                // retransmit or abandon expired requests
                S_TICK_REQ: begin
                    if (!phase_reg) begin
                        if (idx_reg == IDX_W'(REQUEST_ENTRIES)) begin
                            state_reg <= S_FIN;
                        end else begin
                            phase_reg <= 1'b1;
                        end
                    end else if (r_expired && rrd_reg.retries >= max_retries_reg) begin
                        req_vld_reg[ri] <= 1'b0;
                        take_ip_reg     <= rrd_reg.ip;
                        take_emit_reg   <= 1'b0;
                        r_reg           <= '0;
                        w_reg           <= '0;
                        idx_reg         <= idx_reg + IDX_W'(1);
                        phase_reg       <= 1'b0;
                        state_reg       <= S_TAKE;
                    end else if (!stall) begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        phase_reg <= 1'b0;
                    end
                end
                S_FIN: begin
                    if (!emit_sts.hold_valid) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    arpr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (emit_ctl),
        .emit_data (emit_data),
        .sts       (emit_sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ hdl/arpr_checker.sv @@
`timescale 1ns / 1ps

module arpr_checker import arpr_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input arpr_out_t m_data
);

    // stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // one item at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // reset empties the output
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat after reset");

    // request broadcasts go to all ones
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_kind == KIND_ARP_REQ |-> m_data.out_dst_mac == BCAST_MAC)
        else $error("arp request not broadcast");

endmodule

bind arp_resolver_with_retry_core arpr_checker u_arpr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ test/tb_arp_resolver_with_retry_core.sv @@
`timescale 1ns / 1ps

module tb_arp_resolver_with_retry_core;
    import arpr_pkg::*;

    localparam int NCACHE = 8;
    localparam int NREQ   = 8;
    localparam int NPEND  = 16;
    localparam int DRAIN  = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    arpr_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    arpr_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    arp_resolver_with_retry_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow of the resolver
    logic [47:0] my_mac;
    logic [31:0] my_ip;
    logic [31:0] ttl_ms;
    logic [31:0] timeout_ms;
    logic [7:0]  retry_limit;
    logic [31:0] clock_ms;
    logic        c_vld [NCACHE];
    logic [31:0] c_ip  [NCACHE];
    logic [47:0] c_mac [NCACHE];
    logic [31:0] c_t   [NCACHE];
    logic        r_vld [NREQ];
    logic [31:0] r_ip  [NREQ];
    logic [31:0] r_t   [NREQ];
    logic [7:0]  r_cnt [NREQ];
    logic        p_vld [NPEND];
    logic [31:0] p_ip  [NPEND];
    logic [15:0] p_hdl [NPEND];

    arpr_in_t  send_q[$];
    arpr_out_t frames_due[$];
    int        errors = 0;
    bit        hold_sender = 0;
    int        accepted = 0;

    // per-item scratch results
    arpr_out_t beats[$];

    function automatic void push_beat(logic [1:0] kind, logic [47:0] dst,
                                      logic [31:0] tip, logic [47:0] tmac,
                                      logic [15:0] hdl);
        arpr_out_t b;
        if (beats.size() >= MAX_RESULTS) return;
        b.out_kind = kind;
        b.out_dst_mac = dst;
        b.out_target_ip = tip;
        b.out_target_mac = tmac;
        b.out_handle = hdl;
        b.out_last = 1'b0;
        beats.push_back(b);
    endfunction

    function automatic void learn_mapping(logic [31:0] ip, logic [47:0] mac);
        int slot;
        logic [31:0] oldest;
        logic [31:0] age;
        slot = -1;
        oldest = '0;
        for (int i = 0; i < NCACHE; i++)
            if (slot < 0 && c_vld[i] && c_ip[i] == ip) slot = i;
        for (int i = 0; i < NCACHE; i++)
            if (slot < 0 && !c_vld[i]) slot = i;
        if (slot < 0) begin
            slot = 0;
            for (int i = 0; i < NCACHE; i++) begin
                age = clock_ms - c_t[i];
                if (i == 0 || age > oldest) begin
                    oldest = age;
                    slot = i;
                end
            end
        end
        c_vld[slot] = 1'b1;
        c_ip[slot] = ip;
        c_mac[slot] = mac;
        c_t[slot] = clock_ms;
    endfunction

    function automatic void forget_request(logic [31:0] ip);
        for (int i = 0; i < NREQ; i++)
            if (r_vld[i] && r_ip[i] == ip) r_vld[i] = 1'b0;
    endfunction

    // remove queued datagrams for ip, optionally sending them to mac
    function automatic void release_pending(logic [31:0] ip, bit send, logic [47:0] mac);
        int w;
        w = 0;
        for (int r = 0; r < NPEND; r++) begin
            if (p_vld[r]) begin
                if (p_ip[r] == ip) begin
                    if (send) push_beat(KIND_IPV4, mac, '0, '0, p_hdl[r]);
                end else begin
                    p_ip[w] = p_ip[r];
                    p_hdl[w] = p_hdl[r];
                    p_vld[w] = 1'b1;
                    w++;
                end
            end
        end
        for (int k = w; k < NPEND; k++) p_vld[k] = 1'b0;
    endfunction

    function automatic void resolve_item(arpr_in_t it);
        bit known;
        bit asked;
        bit placed;
        beats.delete();
        if (it.req_type == REQ_SEND) begin
            known = 0;
            for (int i = 0; i < NCACHE; i++)
                if (!known && c_vld[i] && c_ip[i] == it.hop_ip) begin
                    push_beat(KIND_IPV4, c_mac[i], '0, '0, it.datagram_handle);
                    known = 1;
                end
            if (!known) begin
                asked = 0;
                for (int i = 0; i < NREQ; i++)
                    if (r_vld[i] && r_ip[i] == it.hop_ip) asked = 1;
                if (!asked) begin
                    push_beat(KIND_ARP_REQ, BCAST_MAC, it.hop_ip, '0, '0);
                    placed = 0;
                    for (int i = 0; i < NREQ; i++)
                        if (!placed && !r_vld[i]) begin
                            r_vld[i] = 1'b1;
                            r_ip[i] = it.hop_ip;
                            r_t[i] = clock_ms;
                            r_cnt[i] = 8'd0;
                            placed = 1;
                        end
                end
                placed = 0;
                for (int i = 0; i < NPEND; i++)
                    if (!placed && !p_vld[i]) begin
                        p_vld[i] = 1'b1;
                        p_ip[i] = it.hop_ip;
                        p_hdl[i] = it.datagram_handle;
                        placed = 1;
                    end
            end
        end else if (it.req_type == REQ_FRAME) begin
            if ((it.frame_dst_mac == my_mac || it.frame_dst_mac == BCAST_MAC)
                && it.payload_ok) begin
                if (it.frame_ethertype == ETH_IPV4) begin
                    push_beat(KIND_DELIVER, '0, '0, '0, it.datagram_handle);
                end else if (it.frame_ethertype == ETH_ARP && it.arp_target_ip == my_ip) begin
                    if (it.arp_opcode == ARP_OP_REQUEST) begin
                        push_beat(KIND_ARP_REPLY, it.arp_sender_mac, it.arp_sender_ip,
                                  it.arp_sender_mac, '0);
                        learn_mapping(it.arp_sender_ip, it.arp_sender_mac);
                        forget_request(it.arp_sender_ip);
                    end else if (it.arp_opcode == ARP_OP_REPLY) begin
                        release_pending(it.arp_sender_ip, 1, it.arp_sender_mac);
                        learn_mapping(it.arp_sender_ip, it.arp_sender_mac);
                        forget_request(it.arp_sender_ip);
                    end
                end
            end
        end else if (it.req_type == REQ_TICK) begin
            clock_ms = clock_ms + 32'(it.elapsed_ms);
            for (int i = 0; i < NCACHE; i++)
                if (c_vld[i] && (clock_ms - c_t[i]) > ttl_ms) c_vld[i] = 1'b0;
            for (int i = 0; i < NREQ; i++) begin
                if (r_vld[i] && (clock_ms - r_t[i]) >= timeout_ms) begin
                    if (r_cnt[i] >= retry_limit) begin
                        r_vld[i] = 1'b0;
                        release_pending(r_ip[i], 0, '0);
                    end else begin
                        push_beat(KIND_ARP_REQ, BCAST_MAC, r_ip[i], '0, '0);
                        r_t[i] = clock_ms;
                        r_cnt[i] = r_cnt[i] + 8'd1;
                    end
                end
            end
        end
        if (beats.size() > 0) beats[beats.size()-1].out_last = 1'b1;
        foreach (beats[k]) frames_due.push_back(beats[k]);
    endfunction

    function automatic void shadow_config(logic [2:0] idx, logic [47:0] val);
        case (idx)
            CFG_LOCAL_MAC:   my_mac = val;
            CFG_LOCAL_IP:    my_ip = val[31:0];
            CFG_CACHE_TTL:   ttl_ms = val[31:0];
            CFG_REQ_TIMEOUT: timeout_ms = val[31:0];
            CFG_MAX_RETRIES: retry_limit = val[7:0];
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // driver: one item per beat from send_q
    int gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                resolve_item(s_data);
                accepted++;
            end
            if (!(s_valid && !s_ready)) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    s_valid <= 1'b0;
                end else if (send_q.size() > 0 && !hold_sender) begin
                    s_data <= send_q.pop_front();
                    s_valid <= 1'b1;
                    gap <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat with the oldest expectation
    int stall = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (frames_due.size() == 0) begin
                    errors++;
                    $display("%0t unexpected beat %h", $time, m_data);
                end else begin
                    arpr_out_t want;
                    want = frames_due.pop_front();
                    if (want.out_kind !== m_data.out_kind ||
                        want.out_dst_mac !== m_data.out_dst_mac ||
                        want.out_target_ip !== m_data.out_target_ip ||
                        want.out_target_mac !== m_data.out_target_mac ||
                        want.out_handle !== m_data.out_handle ||
                        want.out_last !== m_data.out_last) begin
                        errors++;
                        $display("%0t mismatch expected %h actual %h",
                                 $time, want, m_data);
                    end
                end
            end
            if (stall > 0) begin
                stall <= stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall <= pick_gap();
            end
        end
    end

    // item builders
    function automatic arpr_in_t blank_item();
        arpr_in_t it;
        it = '0;
        return it;
    endfunction

    function automatic arpr_in_t send_item(logic [31:0] ip, logic [15:0] h);
        arpr_in_t it;
        it = blank_item();
        it.req_type = REQ_SEND;
        it.hop_ip = ip;
        it.datagram_handle = h;
        return it;
    endfunction

    function automatic arpr_in_t tick_item(logic [15:0] ms);
        arpr_in_t it;
        it = blank_item();
        it.req_type = REQ_TICK;
        it.elapsed_ms = ms;
        return it;
    endfunction

    function automatic arpr_in_t arp_item(logic [15:0] op, logic [31:0] sip,
                                          logic [47:0] smac, logic [31:0] tip,
                                          logic [47:0] dst);
        arpr_in_t it;
        it = blank_item();
        it.req_type = REQ_FRAME;
        it.frame_dst_mac = dst;
        it.frame_ethertype = ETH_ARP;
        it.payload_ok = 1'b1;
        it.arp_opcode = op;
        it.arp_sender_ip = sip;
        it.arp_sender_mac = smac;
        it.arp_target_ip = tip;
        return it;
    endfunction

    function automatic arpr_in_t noise_item();
        logic [287:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom};
        return raw[$bits(arpr_in_t)-1:0];
    endfunction

    // wait until every queued item is in and every result is out
    task automatic drain();
        while (send_q.size() > 0 || s_valid) @(posedge aclk);
        while (frames_due.size() > 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        shadow_config(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    logic [31:0] peer_ip [6];
    logic [47:0] peer_mac [6];

    // random phase with a given pool of peers
    task automatic random_phase(int count);
        int k;
        int r;
        arpr_in_t it;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 5);
            r = $urandom_range(0, 99);
            if (r < 35) it = send_item(peer_ip[k], 16'($urandom));
            else if (r < 50) it = arp_item(ARP_OP_REPLY, peer_ip[k],
                                           $urandom_range(0, 1) ? peer_mac[k]
                                                                : 48'({$urandom, $urandom}),
                                           my_ip, $urandom_range(0, 1) ? my_mac : BCAST_MAC);
            else if (r < 58) it = arp_item(ARP_OP_REQUEST, peer_ip[k], peer_mac[k],
                                           my_ip, BCAST_MAC);
            else if (r < 75) it = tick_item($urandom_range(0, 99) < 80 ?
                                            16'($urandom_range(0, 3000)) : 16'($urandom));
            else if (r < 82) begin
                it = blank_item();
                it.req_type = REQ_FRAME;
                it.frame_dst_mac = my_mac;
                it.frame_ethertype = ETH_IPV4;
                it.payload_ok = 1'b1;
                it.datagram_handle = 16'($urandom);
            end else begin
                it = noise_item();
                if ($urandom_range(0, 1)) it.arp_target_ip = my_ip;
                if ($urandom_range(0, 1)) it.frame_dst_mac = my_mac;
            end
            send_q.push_back(it);
        end
    endtask

    initial begin
        arpr_in_t it;
        int mark;
        my_mac = '0;
        my_ip = '0;
        ttl_ms = TTL_RESET;
        timeout_ms = TIMEOUT_RESET;
        retry_limit = RETRIES_RESET;
        clock_ms = '0;
        for (int i = 0; i < NCACHE; i++) c_vld[i] = 1'b0;
        for (int i = 0; i < NREQ; i++) r_vld[i] = 1'b0;
        for (int i = 0; i < NPEND; i++) p_vld[i] = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(CFG_LOCAL_MAC, 48'h02_00_5E_10_20_30);
        write_reg(CFG_LOCAL_IP, 48'hC0A8_0001);
        for (int i = 0; i < 6; i++) begin
            peer_ip[i] = 32'hC0A8_0010 + i;
            peer_mac[i] = {16'h0A0B, $urandom};
        end
        peer_ip[5] = 32'hFFFF_FFFF;
        peer_mac[5] = BCAST_MAC;

        // directed: misses, retries, replies, requests, ignored frames
        send_q.push_back(send_item(peer_ip[0], 16'h0000));
        send_q.push_back(send_item(peer_ip[0], 16'hFFFF));
        send_q.push_back(send_item(32'h0, 16'h1234));
        send_q.push_back(tick_item(16'd5000));
        send_q.push_back(tick_item(16'hFFFF));
        send_q.push_back(arp_item(ARP_OP_REPLY, peer_ip[0], peer_mac[0], my_ip, my_mac));
        send_q.push_back(send_item(peer_ip[0], 16'h5555));
        send_q.push_back(arp_item(ARP_OP_REQUEST, peer_ip[1], peer_mac[1], my_ip, BCAST_MAC));
        send_q.push_back(send_item(peer_ip[1], 16'hAAAA));
        it = arp_item(ARP_OP_REQUEST, peer_ip[2], peer_mac[2], my_ip, BCAST_MAC);
        it.payload_ok = 1'b0;
        send_q.push_back(it);
        send_q.push_back(arp_item(ARP_OP_REQUEST, peer_ip[2], peer_mac[2], 32'h1, BCAST_MAC));
        send_q.push_back(arp_item(ARP_OP_REQUEST, peer_ip[2], peer_mac[2], my_ip, 48'h1));
        send_q.push_back(arp_item(16'hFFFF, peer_ip[2], peer_mac[2], my_ip, my_mac));
        it = blank_item();
        it.req_type = 2'd3;
        it.datagram_handle = 16'hFFFF;
        send_q.push_back(it);
        it = arp_item(ARP_OP_REQUEST, peer_ip[2], peer_mac[2], my_ip, my_mac);
        it.frame_ethertype = 16'hFFFF;
        send_q.push_back(it);
        it.frame_ethertype = ETH_IPV4;
        it.datagram_handle = 16'hBEEF;
        send_q.push_back(it);
        // pool overflow, then release of the queued datagrams
        for (int i = 0; i < 18; i++) send_q.push_back(send_item(peer_ip[3], 16'(i)));
        send_q.push_back(arp_item(ARP_OP_REPLY, peer_ip[3], peer_mac[3], my_ip, my_mac));
        // request table full
        for (int i = 0; i < 10; i++) send_q.push_back(send_item(32'h0A00_0000 + i, 16'(i)));
        drain();

        // extremes: zero timeouts and no retries
        write_reg(CFG_CACHE_TTL, 48'd0);
        write_reg(CFG_REQ_TIMEOUT, 48'd0);
        write_reg(CFG_MAX_RETRIES, 48'd0);
        random_phase(60);
        drain();

        // pause the sender midway until all results are back
        write_reg(CFG_LOCAL_MAC, BCAST_MAC);
        write_reg(CFG_LOCAL_IP, 48'hFFFF_FFFF);
        write_reg(CFG_CACHE_TTL, 48'hFFFF_FFFF);
        write_reg(CFG_REQ_TIMEOUT, 48'hFFFF_FFFF);
        write_reg(CFG_MAX_RETRIES, 48'hFF);
        mark = accepted + 30;
        random_phase(60);
        while (accepted < mark) @(posedge aclk);
        hold_sender = 1;
        while (frames_due.size() > 0 || s_valid) @(posedge aclk);
        hold_sender = 0;
        drain();

        // typical settings
        write_reg(CFG_LOCAL_MAC, 48'({$urandom, $urandom}));
        write_reg(CFG_LOCAL_IP, 48'($urandom));
        write_reg(CFG_CACHE_TTL, 48'd4000);
        write_reg(CFG_REQ_TIMEOUT, 48'd1500);
        write_reg(CFG_MAX_RETRIES, 48'd2);
        for (int i = 0; i < 6; i++) begin
            peer_ip[i] = $urandom;
            peer_mac[i] = 48'({$urandom, $urandom});
        end
        random_phase(70);
        drain();

        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
